// ----- rtl/ctgr_pkg.sv -----
// Shared types, widths and fit constants for the color temperature gamma ramp.
// No dependencies; every other file in rtl imports this package.
package ctgr_pkg;

  localparam int TEMP_W  = 14;
  localparam int NENT_W  = 13;
  localparam int IDX_W   = 12;
  localparam int LEVEL_W = 16;
  localparam int GAIN_W  = 8;
  localparam int RECIP_W = 32;
  localparam int NUM_W   = IDX_W + 2 * GAIN_W;

  localparam logic [TEMP_W-1:0] TEMP_MIN   = 14'd1000;
  localparam logic [TEMP_W-1:0] TEMP_MAX   = 14'd10000;
  localparam logic [TEMP_W-1:0] TEMP_RESET = 14'd6500;
  localparam logic [TEMP_W-1:0] TEMP_BLUE0 = 14'd1900;
  localparam logic [NENT_W-1:0] MAX_RAMP_ENTRIES = 13'd4096;
  localparam logic [NENT_W-1:0] NENT_RESET       = 13'd256;

  // Register indexes of the configuration port.
  localparam logic [1:0] REG_TEMPERATURE = 2'd0;
  localparam logic [1:0] REG_ENTRIES     = 2'd1;

  // Channel codes of the fit sequencer.
  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;

  // ln(2) in Q24.
  localparam logic [23:0] LN2_Q24 = 24'd11629079;

  typedef struct packed {
    logic signed [33:0] a;
    logic signed [24:0] b;
    logic signed [31:0] c;
    logic [5:0]         off;
  } coef_t;

  // Gains and divisor reciprocal handed from the gain unit to the level pipe.
  typedef struct packed {
    logic [GAIN_W-1:0]  red_gain;
    logic [GAIN_W-1:0]  green_gain;
    logic [GAIN_W-1:0]  blue_gain;
    logic [RECIP_W-1:0] recip;
  } scale_t;

  typedef enum logic [3:0] {
    G_IDLE, G_BASE, G_SUM, G_XSEL, G_NORM, G_SQ, G_LN, G_MUL, G_FIT, G_DIV
  } gstate_t;

  function automatic coef_t fit_coef(input logic [1:0] ch, input logic hot);
    coef_t r;
    case (ch)
      CH_RED: begin
        r.a = 34'sd5905192573;  r.b = 25'sd1916066;   r.c = -32'sd675344400;  r.off = 6'd55;
      end
      CH_GREEN: begin
        if (hot) begin
          r.a = 34'sd5460135091;  r.b = 25'sd1332690;  r.c = -32'sd471193083;
          r.off = 6'd50;
        end else begin
          r.a = -34'sd2604744247; r.b = -25'sd7482126; r.c = 32'sd1753087572;
          r.off = 6'd2;
        end
      end
      default: begin
        r.a = -34'sd4274320446; r.b = 25'sd13881629;  r.c = 32'sd1940787407;  r.off = 6'd10;
      end
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/ctgr_gain_unit.sv -----
// Sequential gain solver: per-channel log fit over a shared squarer, then a
// restoring divide for the ramp divisor reciprocal. Depends on ctgr_pkg.
module ctgr_gain_unit
  import ctgr_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [TEMP_W-1:0] temp,
  input  logic [NENT_W-1:0] nent,
  output logic              busy,
  output scale_t            scale
);

  gstate_t state, state_next;

  logic [30:0] p_int;
  logic [31:0] p_frac;
  logic [30:0] base;
  logic [30:0] x;
  logic [2:0]  k;
  logic [24:0] m;
  logic [23:0] frac;
  logic [5:0]  cnt;
  logic [1:0]  ch;
  logic [50:0] lnp;
  logic signed [56:0] bx;
  logic signed [59:0] cl;
  logic [GAIN_W-1:0] fit_r, fit_g, fit_b;
  logic [NENT_W-1:0] rem;
  logic [32:0] quo;

  logic        hot;
  coef_t       cf;
  logic [49:0] sq;
  logic [25:0] sqs;
  logic [NENT_W:0] rem_sh;
  logic signed [56:0] bq;
  logic signed [59:0] cq;
  logic signed [59:0] f;
  logic signed [59:0] fi;
  logic [GAIN_W-1:0] fit_gain;

  assign hot = temp > TEMP_RESET;
  assign cf  = fit_coef(ch, hot);
  assign sq  = 50'(m) * 50'(m);
  assign sqs = sq[49:24];
  assign rem_sh = {rem, (cnt == 6'd0)};

  always_comb begin
    bq = (bx < 0) ? -((-bx) >>> 24) : (bx >>> 24);
    cq = (cl < 0) ? -((-cl) >>> 24) : (cl >>> 24);
    f  = 60'(cf.a) + 60'(bq) + cq;
    fi = f >>> 24;
    if (f < 0) begin
      fit_gain = '0;
    end else if (fi > 60'sd255) begin
      fit_gain = 8'd255;
    end else begin
      fit_gain = fi[7:0];
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      G_IDLE: state_next = G_IDLE;
      G_BASE: state_next = G_SUM;
      G_SUM:  state_next = G_XSEL;
      G_XSEL: state_next = G_NORM;
      G_NORM: state_next = G_SQ;
      G_SQ:   state_next = (cnt == 6'd23) ? G_LN : G_SQ;
      G_LN:   state_next = G_MUL;
      G_MUL:  state_next = G_FIT;
      G_FIT:  state_next = (ch == CH_BLUE) ? G_DIV : G_XSEL;
      G_DIV:  state_next = (cnt == 6'd32) ? G_IDLE : G_DIV;
      default: state_next = G_IDLE;
    endcase
    if (start) begin
      state_next = G_BASE;
    end
  end

  always_comb begin
    busy = (state != G_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= G_BASE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      G_BASE: begin
        p_int  <= 31'(temp) * 31'(167772);
        p_frac <= 32'({temp, 2'b00}) * 32'd41944;
        ch     <= CH_RED;
      end
      G_SUM: base <= p_int + 31'(p_frac[31:20]);
      G_XSEL: x <= base - 31'({cf.off, 24'b0});
      G_NORM: begin
        if (x[30])      k <= 3'd6;
        else if (x[29]) k <= 3'd5;
        else if (x[28]) k <= 3'd4;
        else if (x[27]) k <= 3'd3;
        else if (x[26]) k <= 3'd2;
        else if (x[25]) k <= 3'd1;
        else            k <= 3'd0;
        if (x[30])      m <= x[30:6];
        else if (x[29]) m <= x[29:5];
        else if (x[28]) m <= x[28:4];
        else if (x[27]) m <= x[27:3];
        else if (x[26]) m <= x[26:2];
        else if (x[25]) m <= x[25:1];
        else            m <= x[24:0];
        frac <= '0;
        cnt  <= '0;
      end
      G_SQ: begin
        m    <= sqs[25] ? sqs[25:1] : sqs[24:0];
        frac <= {frac[22:0], sqs[25]};
        cnt  <= cnt + 6'd1;
      end
      G_LN: lnp <= 51'({k, frac}) * 51'(LN2_Q24);
      G_MUL: begin
        bx <= 57'(cf.b) * $signed({26'b0, x});
        cl <= 60'(cf.c) * $signed({33'b0, lnp[50:24]});
      end
      G_FIT: begin
        case (ch)
          CH_RED:   fit_r <= fit_gain;
          CH_GREEN: fit_g <= fit_gain;
          default:  fit_b <= fit_gain;
        endcase
        ch  <= ch + 2'd1;
        cnt <= '0;
        rem <= '0;
        quo <= '0;
      end
      G_DIV: begin
        // One quotient bit of 2^32 / nent per cycle.
        if (rem_sh >= {1'b0, nent}) begin
          rem <= NENT_W'(rem_sh - {1'b0, nent});
          quo <= {quo[31:0], 1'b1};
        end else begin
          rem <= rem_sh[NENT_W-1:0];
          quo <= {quo[31:0], 1'b0};
        end
        cnt <= cnt + 6'd1;
      end
      default: ;
    endcase
  end

  always_comb begin
    scale.red_gain   = hot ? fit_r : 8'd255;
    scale.green_gain = fit_g;
    if (temp <= TEMP_BLUE0) begin
      scale.blue_gain = '0;
    end else if (temp < TEMP_RESET) begin
      scale.blue_gain = fit_b;
    end else begin
      scale.blue_gain = 8'd255;
    end
    scale.recip = quo[31:0];
  end

endmodule

// ----- rtl/ctgr_level_pipe.sv -----
// Four-stage ramp level pipeline: index times gain, reciprocal divide with
// one correction step, saturating output register. Depends on ctgr_pkg.
module ctgr_level_pipe
  import ctgr_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               hold,
  input  scale_t             scale,
  input  logic [NENT_W-1:0]  nent,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [IDX_W-1:0]   entry_index,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [LEVEL_W-1:0] red_level,
  output logic [LEVEL_W-1:0] green_level,
  output logic [LEVEL_W-1:0] blue_level,
  output logic [GAIN_W-1:0]  red_gain,
  output logic [GAIN_W-1:0]  green_gain,
  output logic [GAIN_W-1:0]  blue_gain
);

  logic advance;
  logic v_a, v_b, v_c;
  logic [2:0][NUM_W-1:0] num_a, num_b, num_c, qe_b, qe_c, qn_c;
  logic [2:0][LEVEL_W-1:0] lvl;
  logic [2:0][GAIN_W-1:0]  gain;
  logic unit_div;

  assign advance  = !out_valid || out_ready;
  assign in_ready = advance && !hold;
  assign unit_div = (nent == NENT_W'(1));
  assign gain[0]  = scale.red_gain;
  assign gain[1]  = scale.green_gain;
  assign gain[2]  = scale.blue_gain;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_a <= 1'b0;
      v_b <= 1'b0;
      v_c <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      v_a <= in_valid && in_ready;
      v_b <= v_a;
      v_c <= v_b;
      out_valid <= v_c;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int i = 0; i < 3; i++) begin
        // gain * 257 is the gain byte repeated
        num_a[i] <= NUM_W'(entry_index) * NUM_W'({gain[i], gain[i]});
        num_b[i] <= num_a[i];
        qe_b[i]  <= unit_div ? num_a[i]
                    : NUM_W'((60'(num_a[i]) * 60'(scale.recip)) >> 32);
        num_c[i] <= num_b[i];
        qe_c[i]  <= qe_b[i];
        qn_c[i]  <= NUM_W'(qe_b[i] * NUM_W'(nent));
        if (NUM_W'(num_c[i] - qn_c[i]) >= NUM_W'(nent)) begin
          lvl[i] <= ((qe_c[i] + NUM_W'(1)) > NUM_W'(16'hFFFF)) ? 16'hFFFF
                    : LEVEL_W'(qe_c[i] + NUM_W'(1));
        end else begin
          lvl[i] <= (qe_c[i] > NUM_W'(16'hFFFF)) ? 16'hFFFF : LEVEL_W'(qe_c[i]);
        end
      end
      red_gain   <= gain[0];
      green_gain <= gain[1];
      blue_gain  <= gain[2];
    end
  end

  assign red_level   = lvl[0];
  assign green_level = lvl[1];
  assign blue_level  = lvl[2];

endmodule

// ----- rtl/color_temperature_gamma_ramp.sv -----
// Color temperature gamma ramp: per-channel gains from a white point, then
// ramp levels floor(65535*index*gain/(entries*255)). Output valid follows the input
// transfer through the pipe registers; one item per cycle, a stalled output holds the pipe.
// After reset and after each config write the gain unit runs with in_ready low:
// setup states G_BASE and G_SUM, three log fits (one per channel), a 33-step divide.
// Reset: synchronous, active high; loads 6500 K and 256 entries.
module color_temperature_gamma_ramp
  import ctgr_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [TEMP_W-1:0]  cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [IDX_W-1:0]   entry_index,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [LEVEL_W-1:0] red_level,
  output logic [LEVEL_W-1:0] green_level,
  output logic [LEVEL_W-1:0] blue_level,
  output logic [GAIN_W-1:0]  red_gain,
  output logic [GAIN_W-1:0]  green_gain,
  output logic [GAIN_W-1:0]  blue_gain
);

  logic [TEMP_W-1:0] temp;
  logic [NENT_W-1:0] nent;
  logic              cfg_xfer;
  logic              busy;
  scale_t            scale;
  logic [NENT_W-1:0] nent_wr;

  // Configuration is always taken; a transfer restarts the gain unit.
  assign cfg_ready = 1'b1;
  assign cfg_xfer  = cfg_valid && cfg_ready;
  assign nent_wr   = cfg_data[NENT_W-1:0];

  // Hold the saturated register values so downstream logic sees legal ranges.
  always_ff @(posedge clk) begin
    if (rst) begin
      temp <= TEMP_RESET;
      nent <= NENT_RESET;
    end else if (cfg_xfer) begin
      case (cfg_index)
        REG_TEMPERATURE: begin
          if (cfg_data < TEMP_MIN)      temp <= TEMP_MIN;
          else if (cfg_data > TEMP_MAX) temp <= TEMP_MAX;
          else                          temp <= cfg_data;
        end
        REG_ENTRIES: begin
          if (nent_wr == '0)                   nent <= NENT_W'(1);
          else if (nent_wr > MAX_RAMP_ENTRIES) nent <= MAX_RAMP_ENTRIES;
          else                                 nent <= nent_wr;
        end
        default: ;  // drop writes to unknown registers
      endcase
    end
  end

  ctgr_gain_unit u_gain (
    .clk   (clk),
    .rst   (rst),
    .start (cfg_xfer),
    .temp  (temp),
    .nent  (nent),
    .busy  (busy),
    .scale (scale)
  );

  // Stall input while gains are being recomputed.
  ctgr_level_pipe u_pipe (
    .clk         (clk),
    .rst         (rst),
    .hold        (busy),
    .scale       (scale),
    .nent        (nent),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .entry_index (entry_index),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .red_level   (red_level),
    .green_level (green_level),
    .blue_level  (blue_level),
    .red_gain    (red_gain),
    .green_gain  (green_gain),
    .blue_gain   (blue_gain)
  );

endmodule

// ----- verif/ctgr_checker.sv -----
// Checker for the color temperature gamma ramp: shadows the config registers,
// predicts gains and ramp levels per input transfer, and compares each result.
// Depends on ctgr_pkg for widths and register indexes.
module ctgr_checker
  import ctgr_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [TEMP_W-1:0]  cfg_data,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [IDX_W-1:0]   entry_index,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [LEVEL_W-1:0] red_level,
  input  logic [LEVEL_W-1:0] green_level,
  input  logic [LEVEL_W-1:0] blue_level,
  input  logic [GAIN_W-1:0]  red_gain,
  input  logic [GAIN_W-1:0]  green_gain,
  input  logic [GAIN_W-1:0]  blue_gain,
  output int                 pending,
  output int                 failures
);

  localparam longint ONE_Q24 = 64'sd16777216;

  typedef struct {
    logic [LEVEL_W-1:0] red_lvl;
    logic [LEVEL_W-1:0] green_lvl;
    logic [LEVEL_W-1:0] blue_lvl;
    logic [GAIN_W-1:0]  red_g;
    logic [GAIN_W-1:0]  green_g;
    logic [GAIN_W-1:0]  blue_g;
  } ramp_entry_t;

  logic [TEMP_W-1:0] white_point;
  logic [NENT_W-1:0] entry_count;
  ramp_entry_t       expected_entries[$];

  function automatic longint nano_to_q24(input longint nano);
    return (nano * ONE_Q24) / 64'sd1000000000;
  endfunction

  function automatic longint log_q24(input longint x);
    longint unsigned m;
    longint unsigned frac;
    int              k;
    frac = 0;
    k = 0;
    if (x < ONE_Q24) return 0;
    while ((longint'(unsigned'(x)) >> k) >= 2 * ONE_Q24) k++;
    m = longint'(unsigned'(x)) >> k;
    for (int i = 0; i < 24; i++) begin
      m = (m * m) >> 24;
      if (m >= 2 * ONE_Q24) begin
        m = m >> 1;
        frac |= 64'd1 << (23 - i);
      end
    end
    return longint'(((longint'(k) << 24 | frac) * nano_to_q24(64'sd693147180)) >> 24);
  endfunction

  function automatic logic [GAIN_W-1:0] fit_gain(input int temp, input longint off,
                                                 input longint a, input longint b,
                                                 input longint c);
    longint x, f, g;
    x = (longint'(temp) * ONE_Q24) / 100 - off * ONE_Q24;
    f = nano_to_q24(a) + (nano_to_q24(b) * x) / ONE_Q24
        + (nano_to_q24(c) * log_q24(x)) / ONE_Q24;
    if (f < 0) return 0;
    g = f / ONE_Q24;
    return (g > 255) ? 8'd255 : GAIN_W'(g);
  endfunction

  function automatic logic [LEVEL_W-1:0] ramp_level(input int idx, input int gain,
                                                    input int n);
    longint v;
    v = (64'd65535 * idx * gain) / (longint'(n) * 255);
    return (v > 65535) ? 16'hFFFF : LEVEL_W'(v);
  endfunction

  function automatic ramp_entry_t predict_entry(input logic [IDX_W-1:0] idx);
    ramp_entry_t e;
    int          temp, n;
    temp = white_point;
    n = entry_count;
    if (temp < 1000) temp = 1000;
    if (temp > 10000) temp = 10000;
    if (n < 1) n = 1;
    if (n > 4096) n = 4096;
    // Red saturates at or below the neutral point, otherwise follows the hot fit.
    if (temp <= 6500) e.red_g = 8'd255;
    else e.red_g = fit_gain(temp, 55, 64'sd351976905668, 64'sd114206453,
                            -64'sd40253663093);
    if (temp <= 6500)
      e.green_g = fit_gain(temp, 2, -64'sd155254855627, -64'sd445969504,
                           64'sd104492161993);
    else
      e.green_g = fit_gain(temp, 50, 64'sd325449412571, 64'sd79434565,
                           -64'sd28085296350);
    // Blue is dark below the candle band and full from the neutral point up.
    if (temp <= 1900) e.blue_g = 8'd0;
    else if (temp < 6500)
      e.blue_g = fit_gain(temp, 10, -64'sd254769351841, 64'sd827409606,
                          64'sd115679944010);
    else e.blue_g = 8'd255;
    e.red_lvl   = ramp_level(idx, e.red_g, n);
    e.green_lvl = ramp_level(idx, e.green_g, n);
    e.blue_lvl  = ramp_level(idx, e.blue_g, n);
    return e;
  endfunction

  task automatic report(input string field, input int want, input int got);
    $display("[%0t] %s: expected %0d, got %0d", $realtime, field, want, got);
    failures++;
  endtask

  initial failures = 0;
  assign pending = expected_entries.size();

  always @(posedge clk) begin
    ramp_entry_t e;
    if (rst) begin
      white_point <= TEMP_RESET;
      entry_count <= NENT_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_TEMPERATURE) white_point <= cfg_data;
        else if (cfg_index == REG_ENTRIES) entry_count <= cfg_data[NENT_W-1:0];
      end
      if (in_valid && in_ready) expected_entries.push_back(predict_entry(entry_index));
      if (out_valid && out_ready) begin
        if (expected_entries.size() == 0) begin
          report("unexpected result", 0, 1);
        end else begin
          e = expected_entries.pop_front();
          if (red_level !== e.red_lvl) report("red_level", e.red_lvl, red_level);
          if (green_level !== e.green_lvl) report("green_level", e.green_lvl, green_level);
          if (blue_level !== e.blue_lvl) report("blue_level", e.blue_lvl, blue_level);
          if (red_gain !== e.red_g) report("red_gain", e.red_g, red_gain);
          if (green_gain !== e.green_g) report("green_gain", e.green_g, green_gain);
          if (blue_gain !== e.blue_g) report("blue_gain", e.blue_g, blue_gain);
        end
      end
    end
  end

endmodule

// ----- verif/tb_color_temperature_gamma_ramp.sv -----
// Testbench top for the color temperature gamma ramp: clock, reset, config
// phases, bursty entry stimulus and a stalling receiver. Depends on ctgr_pkg,
// the block and ctgr_checker.
module tb_color_temperature_gamma_ramp;
  import ctgr_pkg::*;

  localparam int IDLE_LIMIT = 3000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = REG_TEMPERATURE;
  logic [TEMP_W-1:0]  cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [IDX_W-1:0]   entry_index = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [LEVEL_W-1:0] red_level, green_level, blue_level;
  logic [GAIN_W-1:0]  red_gain, green_gain, blue_gain;
  int                 pending, failures;
  int                 burst_left = 0;
  int                 idle_cycles = 0;
  int                 stall_mode = 0;
  int                 stall_cnt = 0;
  int                 ramp_len = 256;
  int                 temps[12] = '{1000, 0, 1900, 1901, 6499, 6500, 6501, 10000, 16383,
                                    2700, 4000, 8500};
  int                 ents[12]  = '{256, 1, 4096, 8191, 0, 4096, 1000, 4096, 3, 4096,
                                    17, 4096};

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  color_temperature_gamma_ramp uut (.*);
  ctgr_checker checker_i (.*);

  // Receiver: switch at random between always-ready, coin-flip and mostly-stalled patterns.
  always @(negedge clk) begin
    if (stall_cnt == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_cnt = $urandom_range(8, 80);
    end
    stall_cnt--;
    case (stall_mode)
      0: out_ready = 1'b1;
      1: out_ready = 1'($urandom_range(0, 1));
      default: out_ready = ($urandom_range(0, 3) == 0);
    endcase
  end

  // Watchdog: any transfer on any channel resets the idle count.
  always @(posedge clk) begin
    if ((cfg_valid && cfg_ready) || (in_valid && in_ready) || (out_valid && out_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("color_temperature_gamma_ramp: mismatch");
      $finish;
    end
  end

  // Drain all outstanding results, then write one register.
  task automatic write_reg(input logic [1:0] idx, input int value);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = TEMP_W'(value);
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
    if (idx == REG_ENTRIES) begin
      ramp_len = value % 8192;
      if (ramp_len < 1) ramp_len = 1;
      if (ramp_len > 4096) ramp_len = 4096;
    end
  endtask

  // Send one entry; open a new burst after a random gap when the last one ends.
  task automatic send_entry(input int idx);
    if (burst_left == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(0, 12)) @(negedge clk);
      burst_left = $urandom_range(1, 24);
    end
    in_valid = 1'b1;
    entry_index = IDX_W'(idx);
    do @(posedge clk); while (!in_ready);
    burst_left--;
    @(negedge clk);
  endtask

  task automatic run_phase(input int temp, input int ents_val, input int count);
    write_reg(REG_TEMPERATURE, temp);
    write_reg(REG_ENTRIES, ents_val);
    for (int i = 0; i < count; i++) begin
      // Mostly in-range indexes; some past the end to hit level saturation.
      if ($urandom_range(0, 99) < 85) send_entry($urandom_range(0, ramp_len - 1));
      else send_entry($urandom_range(0, 4095));
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: reset settings, edge indexes, then index extremes at full size.
    send_entry(0);
    send_entry(255);
    send_entry(256);
    send_entry(4095);
    write_reg(REG_ENTRIES, 4096);
    send_entry(0);
    send_entry(4095);
    send_entry(12'hAAA);
    send_entry(12'h555);
    // Out-of-range register indexes must be ignored.
    write_reg(2'd2, 1234);
    write_reg(2'd3, 16383);
    send_entry(4095);

    for (int p = 0; p < 12; p++) run_phase(temps[p], ents[p], 90);
    for (int p = 0; p < 5; p++)
      run_phase($urandom_range(0, 16383), $urandom_range(0, 8191), 110);

    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (10) @(posedge clk);
    if (failures == 0)
      $display("color_temperature_gamma_ramp: match");
    else
      $display("color_temperature_gamma_ramp: mismatch");
    $finish;
  end

endmodule

// ----- color_temperature_gamma_ramp.f -----
rtl/ctgr_pkg.sv
rtl/ctgr_gain_unit.sv
rtl/ctgr_level_pipe.sv
rtl/color_temperature_gamma_ramp.sv
verif/ctgr_checker.sv
verif/tb_color_temperature_gamma_ramp.sv
